/* sv/dqe_pkg.sv */
// shared types and constants of the dns query-name encoder
// used by dqe_ctrl, dqe_datapath and dns_qname_encoder_unit; no dependencies
package dqe_pkg;

  // longest label kept; further characters of a label are dropped
  localparam int LABEL_MAX   = 63;
  localparam int CNT_W       = $clog2(LABEL_MAX + 1);
  localparam int ADDR_W      = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;
  // zero byte, query type and query class after the name
  localparam int TAIL_BYTES  = 5;
  localparam int IDX_W       = $clog2(LABEL_MAX + 1 + TAIL_BYTES + 1);
  localparam int CFG_INDEX_W = 8;

  localparam logic [7:0] DOT_CHAR = 8'd46;
  localparam logic [7:0] END_CHAR = 8'd0;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_QUERY_TYPE  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_QUERY_CLASS = CFG_INDEX_W'(1);

  // controller to datapath
  typedef struct packed {
    logic store_char;  // take a plain character into the label
    logic start;       // dot or end word accepted, set up an emission
    logic rd;          // read the label memory at the current byte
    logic place;       // put the current byte into the pair / output
  } dqe_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic             char_plain;  // input word is a label character
    logic             pair_done;   // placing the byte completes a result
    logic             out_free;    // output register can take a result
    logic             byte_last;   // current byte ends the emission
    logic             have_first;  // first half of a pair is held
    logic [CNT_W-1:0] count;       // characters of the pending label
  } dqe_status_t;

endpackage

/* sv/dqe_ctrl.sv */
// controller state machine of the dns query-name encoder
// depends on dqe_pkg for the command and status structs
module dqe_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  dqe_pkg::dqe_status_t status,
  output dqe_pkg::dqe_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_PLACE
  } state_t;

  state_t state;
  state_t state_next;

  // commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (status.char_plain) begin
            cmd.store_char = 1'b1;
          end else begin
            cmd.start  = 1'b1;
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = ST_PLACE;
      end
      ST_PLACE: begin
        // hold while a finished pair has nowhere to go
        if (!status.pair_done || status.out_free) begin
          cmd.place  = 1'b1;
          state_next = status.byte_last ? ST_IDLE : ST_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* sv/dqe_datapath.sv */
// datapath of the dns query-name encoder: label memory, byte sequencing,
// pair packing, output register and type/class registers; depends on dqe_pkg
module dqe_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [7:0]                            s_tdata,
  input  logic                                  cfg_valid,
  input  logic [dqe_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [15:0]                           cfg_data,
  input  dqe_pkg::dqe_cmd_t                     cmd,
  output dqe_pkg::dqe_status_t                  status,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [15:0]                           m_tdata,
  output logic [1:0]                            m_tuser,
  output logic                                  m_tlast
);

  logic [7:0]                  label_mem [dqe_pkg::LABEL_MAX];
  logic [7:0]                  rd_data;
  logic [dqe_pkg::CNT_W-1:0]   count;
  logic                        trunc;
  logic [15:0]                 query_type;
  logic [15:0]                 query_class;
  logic [dqe_pkg::IDX_W-1:0]   idx;
  logic [dqe_pkg::IDX_W-1:0]   lab_len;
  logic [dqe_pkg::IDX_W-1:0]   last_idx;
  logic                        ovf;
  logic                        have_first;
  logic [7:0]                  first;
  logic [7:0]                  cur_byte;
  logic [dqe_pkg::IDX_W-1:0]   tail_pos;
  logic [dqe_pkg::IDX_W-1:0]   lab_len_new;
  logic                        is_end;
  logic                        byte_last;
  logic                        pair_done;
  logic                        out_free;
  logic                        room;
  logic                        load_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      query_type  <= 16'd1;
      query_class <= 16'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        dqe_pkg::REG_QUERY_TYPE:  query_type  <= cfg_data;
        dqe_pkg::REG_QUERY_CLASS: query_class <= cfg_data;
        default: ;
      endcase
    end
  end

  assign room = (count < dqe_pkg::CNT_W'(dqe_pkg::LABEL_MAX));

  // label memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.store_char && room) begin
      label_mem[dqe_pkg::ADDR_W'(count)] <= s_tdata;
    end
    if (cmd.rd) begin
      rd_data <= label_mem[dqe_pkg::ADDR_W'(idx - dqe_pkg::IDX_W'(1))];
    end
  end

  // emission setup: label part length and index of the final byte
  assign is_end      = (s_tdata == dqe_pkg::END_CHAR);
  assign lab_len_new = (!is_end || count != '0)
                       ? dqe_pkg::IDX_W'(count) + dqe_pkg::IDX_W'(1)
                       : '0;

  // current byte of the emission
  assign tail_pos = idx - lab_len;
  always_comb begin
    if (idx < lab_len) begin
      cur_byte = (idx == '0) ? 8'(count) : rd_data;
    end else begin
      case (tail_pos)
        dqe_pkg::IDX_W'(1): cur_byte = query_type[15:8];
        dqe_pkg::IDX_W'(2): cur_byte = query_type[7:0];
        dqe_pkg::IDX_W'(3): cur_byte = query_class[15:8];
        dqe_pkg::IDX_W'(4): cur_byte = query_class[7:0];
        default:            cur_byte = 8'd0;
      endcase
    end
  end

  assign byte_last = (idx == last_idx);
  assign pair_done = have_first || byte_last;
  assign out_free  = !m_tvalid || m_tready;
  assign load_out  = cmd.place && pair_done;

  // label state and byte sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      trunc      <= 1'b0;
      have_first <= 1'b0;
    end else begin
      if (cmd.store_char) begin
        if (room) begin
          count <= count + dqe_pkg::CNT_W'(1);
        end else begin
          trunc <= 1'b1;
        end
      end
      if (cmd.place) begin
        have_first <= !pair_done;
        if (byte_last) begin
          count <= '0;
          trunc <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      idx      <= '0;
      lab_len  <= lab_len_new;
      last_idx <= lab_len_new
                  + (is_end ? dqe_pkg::IDX_W'(dqe_pkg::TAIL_BYTES) : '0)
                  - dqe_pkg::IDX_W'(1);
      ovf      <= trunc;
    end else if (cmd.place) begin
      idx <= idx + dqe_pkg::IDX_W'(1);
    end
    if (cmd.place && !pair_done) begin
      first <= cur_byte;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata    <= have_first ? {cur_byte, first} : {8'd0, cur_byte};
      m_tuser[0] <= have_first;
      m_tuser[1] <= ovf;
      m_tlast    <= byte_last;
    end
  end

  assign status.char_plain = (s_tdata != dqe_pkg::DOT_CHAR) && !is_end;
  assign status.pair_done  = pair_done;
  assign status.out_free   = out_free;
  assign status.byte_last  = byte_last;
  assign status.have_first = have_first;
  assign status.count      = count;

endmodule

/* sv/dns_qname_encoder_unit.sv */
// top level of the dns query-name encoder
// instantiates dqe_ctrl and dqe_datapath; depends on dqe_pkg
//
// - s_* takes one hostname character per word in s_tdata; a dot separates
//   labels and a zero character ends the name
// - m_* gives the encoded name two bytes per word: a length byte and the
//   label characters on each dot, and at the end any pending label, a zero
//   byte, query type and query class, both big-endian; m_tlast marks the
//   final word caused by one dot or end character
// - cfg_* writes query_type (index 0) and query_class (index 1); other
//   indexes are ignored; cfg_ready is always high
// - a label character is stored as it is taken; a dot or end character
//   starts an emission of n bytes, each taken through ST_READ (label
//   memory read) and then ST_PLACE, two bytes to a word; the next
//   character is taken only once the emission is done
// - characters past 63 in a label are dropped and label_overflow is set
//   on every word of that label's emission
// - a low m_tready holds a finished word in the output register and the
//   byte sequencer waits; reset empties the label, sets type and class to 1
module dns_qname_encoder_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,   // [7:0] ch
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [15:0]                         m_tdata,   // [7:0] first_byte, [15:8] second_byte
  output logic [1:0]                          m_tuser,   // [0] second_valid, [1] label_overflow
  output logic                                m_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dqe_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [15:0]                         cfg_data
);

  dqe_pkg::dqe_cmd_t    cmd;
  dqe_pkg::dqe_status_t status;

  assign cfg_ready = 1'b1;

  dqe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  dqe_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // label count never passes the limit
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    status.count <= dqe_pkg::CNT_W'(dqe_pkg::LABEL_MAX))
    else $error("label count above limit");

  // no half pair left behind once the controller takes input again
  a_no_half_pair: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !status.have_first)
    else $error("half pair held while idle");

  // a finished pair is only placed when the output register can take it
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.place && status.pair_done) |-> status.out_free)
    else $error("output word overwritten");

endmodule

/* dv/dns_qname_encoder_checker.sv */
// checker of the dns query-name encoder: predicts encoded words from the
// characters and register writes it sees, compares every output word
// depends on dqe_pkg; instantiated beside i_dut by dns_qname_encoder_unit_tb
module dns_qname_encoder_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [7:0]                      s_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [15:0]                     m_tdata,
  input  logic [1:0]                      m_tuser,
  input  logic                            m_tlast,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [dqe_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                     cfg_data,
  output int                              mismatch_count,
  output int                              words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       second_valid;
    logic       label_overflow;
    logic       last;
  } qname_word_t;

  // mirror of the block state and registers
  logic [7:0]  label_chars [dqe_pkg::LABEL_MAX];
  int          label_len;
  logic        label_cut;
  logic [15:0] qtype;
  logic [15:0] qclass;

  qname_word_t expected_words [$];

  initial begin
    mismatch_count = 0;
    words_pending  = 0;
    label_len      = 0;
    label_cut      = 1'b0;
    qtype          = 16'd1;
    qclass         = 16'd1;
  end

  // one accepted character: store it, or build the emission it triggers
  task automatic encode_char(input logic [7:0] c);
    logic [7:0]  bytes [$];
    qname_word_t w;
    int          i;
    if (c != dqe_pkg::DOT_CHAR && c != dqe_pkg::END_CHAR) begin
      if (label_len < dqe_pkg::LABEL_MAX) begin
        label_chars[label_len] = c;
        label_len++;
      end else begin
        label_cut = 1'b1;
      end
    end else begin
      // a dot always emits its label, the end only a non-empty one
      if (c == dqe_pkg::DOT_CHAR || label_len != 0) begin
        bytes.push_back(8'(label_len));
        for (i = 0; i < label_len; i++) bytes.push_back(label_chars[i]);
      end
      if (c == dqe_pkg::END_CHAR) begin
        bytes.push_back(8'h00);
        bytes.push_back(qtype[15:8]);
        bytes.push_back(qtype[7:0]);
        bytes.push_back(qclass[15:8]);
        bytes.push_back(qclass[7:0]);
      end
      // two bytes per word from the start of the emission
      for (i = 0; i < bytes.size(); i += 2) begin
        w.first_byte     = bytes[i];
        w.second_valid   = (i + 1 < bytes.size());
        w.second_byte    = w.second_valid ? bytes[i+1] : 8'h00;
        w.label_overflow = label_cut;
        w.last           = (i + 2 >= bytes.size());
        expected_words.push_back(w);
      end
      label_len = 0;
      label_cut = 1'b0;
    end
  endtask

  // compare one output word with the oldest prediction
  task automatic check_word(input qname_word_t got);
    qname_word_t want;
    if (expected_words.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: unexpected word first=%h second=%h sv=%b ovf=%b last=%b",
                 $realtime, got.first_byte, got.second_byte, got.second_valid,
                 got.label_overflow, got.last);
    end else begin
      want = expected_words.pop_front();
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: word mismatch", $realtime);
          $display("  exp first=%h second=%h sv=%b ovf=%b last=%b",
                   want.first_byte, want.second_byte, want.second_valid,
                   want.label_overflow, want.last);
          $display("  got first=%h second=%h sv=%b ovf=%b last=%b",
                   got.first_byte, got.second_byte, got.second_valid,
                   got.label_overflow, got.last);
        end
      end
    end
  endtask

  // sample all three channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      label_len = 0;
      label_cut = 1'b0;
      qtype     = 16'd1;
      qclass    = 16'd1;
      expected_words.delete();
    end else begin
      if (m_tvalid && m_tready)
        check_word({m_tdata[7:0], m_tdata[15:8], m_tuser[0], m_tuser[1], m_tlast});
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          dqe_pkg::REG_QUERY_TYPE:  qtype  = cfg_data;
          dqe_pkg::REG_QUERY_CLASS: qclass = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        encode_char(s_tdata);
    end
    words_pending = expected_words.size();
  end

endmodule

/* dv/dns_qname_encoder_unit_tb.sv */
// testbench top of the dns query-name encoder: directed and random hostnames
// under several query type/class settings, with random idling on both sides
// depends on dqe_pkg, dns_qname_encoder_unit and dns_qname_encoder_checker
module dns_qname_encoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            s_tvalid  = 1'b0;
  logic                            s_tready;
  logic [7:0]                      s_tdata   = 8'h00;
  logic                            m_tvalid;
  logic                            m_tready  = 1'b1;
  logic [15:0]                     m_tdata;
  logic [1:0]                      m_tuser;
  logic                            m_tlast;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [dqe_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [15:0]                     cfg_data  = '0;

  int   mismatch_count;
  int   words_pending;
  int   chars_sent = 0;
  bit   calm       = 1'b0;
  int   stall_left = 0;

  always #5 clk = ~clk;

  dns_qname_encoder_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dns_qname_encoder_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .m_tlast        (m_tlast),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .words_pending  (words_pending)
  );

  // receiver stalls in random bursts, none once calm
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!rst && !calm && $urandom_range(0, 4) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // one character word, with an occasional gap ahead of it
  task automatic put_char(input logic [7:0] c);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    chars_sent++;
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == dqe_pkg::DOT_CHAR);
    return c;
  endfunction

  task automatic send_label(input int len);
    repeat (len) put_char(plain_char());
  endtask

  // a mostly well-formed hostname; some are broken or carry raw noise
  task automatic send_random_name();
    int labels;
    int len;
    int roll;
    labels = $urandom_range(1, 4);
    for (int j = 0; j < labels; j++) begin
      roll = $urandom_range(0, 19);
      if (roll == 0)     len = $urandom_range(60, 68);
      else if (roll < 3) len = 0;
      else               len = $urandom_range(1, 9);
      send_label(len);
      if (j < labels - 1 || $urandom_range(0, 5) == 0) put_char(dqe_pkg::DOT_CHAR);
    end
    roll = $urandom_range(0, 9);
    if (roll == 0) begin
      // raw bytes, any value
      repeat ($urandom_range(1, 6)) put_char(8'($urandom_range(0, 255)));
    end else if (roll != 1) begin
      put_char(dqe_pkg::END_CHAR);
    end
  endtask

  // phase of random names, opening with labels around the length limit
  task automatic run_phase(input int target);
    int stop_at;
    stop_at = chars_sent + target;
    send_label(dqe_pkg::LABEL_MAX);
    put_char(dqe_pkg::DOT_CHAR);
    send_label(dqe_pkg::LABEL_MAX + 3);
    put_char(dqe_pkg::END_CHAR);
    while (chars_sent < stop_at) send_random_name();
  endtask

  // the block is idle once all words are in and a settling wait has passed
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input logic [dqe_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed names under the reset values of type and class
    put_char(dqe_pkg::END_CHAR);
    put_char(dqe_pkg::DOT_CHAR);
    put_char(8'hFF);
    put_char(8'h01);
    put_char(8'h2F);
    put_char(dqe_pkg::DOT_CHAR);
    put_char(8'h80);
    put_char(8'h7F);
    put_char(dqe_pkg::END_CHAR);
    put_char(8'h41);
    put_char(dqe_pkg::DOT_CHAR);
    put_char(dqe_pkg::END_CHAR);
    put_char(8'h55);
    put_char(8'hAA);
    put_char(dqe_pkg::DOT_CHAR);
    put_char(dqe_pkg::DOT_CHAR);
    put_char(8'h2D);
    put_char(dqe_pkg::END_CHAR);
    wait_idle();

    // all-zero type and class
    write_reg(dqe_pkg::REG_QUERY_TYPE, 16'h0000);
    write_reg(dqe_pkg::REG_QUERY_CLASS, 16'h0000);
    run_phase(120);
    wait_idle();

    // all-ones, plus an index that must be ignored
    write_reg(dqe_pkg::REG_QUERY_TYPE, 16'hFFFF);
    write_reg(dqe_pkg::REG_QUERY_CLASS, 16'hFFFF);
    write_reg(dqe_pkg::CFG_INDEX_W'($urandom_range(2, 255)),
              16'($urandom_range(0, 65535)));
    run_phase(120);
    wait_idle();

    // random settings, no idling for the rest of the run
    write_reg(dqe_pkg::REG_QUERY_TYPE, 16'($urandom_range(0, 65535)));
    write_reg(dqe_pkg::REG_QUERY_CLASS, 16'($urandom_range(0, 65535)));
    calm = 1'b1;
    run_phase(120);
    wait_idle();

    if (mismatch_count == 0 && words_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* dns_qname_encoder_unit.f */
sv/dqe_pkg.sv
sv/dqe_ctrl.sv
sv/dqe_datapath.sv
sv/dns_qname_encoder_unit.sv
dv/dns_qname_encoder_checker.sv
dv/dns_qname_encoder_unit_tb.sv
